/* hdl/lsp_pkg.sv */
// shared types, constants and helpers for the lidar person cluster block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lsp_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int CW = 34;
	localparam int MUL_W = 52;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [17:0] COORD_LIM = 18'sd65535;

	typedef struct packed {
		logic signed [CW-1:0] s;
		logic signed [CW-1:0] c;
	} cordic_res_t;

	function automatic logic signed [CW-1:0] atan_turn(input logic [3:0] i);
		logic signed [CW-1:0] v;
		begin
			unique case (i)
				4'd0: v = 34'sd536870912;
				4'd1: v = 34'sd316933406;
				4'd2: v = 34'sd167458907;
				4'd3: v = 34'sd85004756;
				4'd4: v = 34'sd42667331;
				4'd5: v = 34'sd21354465;
				4'd6: v = 34'sd10679838;
				4'd7: v = 34'sd5340245;
				4'd8: v = 34'sd2670163;
				4'd9: v = 34'sd1335087;
				4'd10: v = 34'sd667544;
				4'd11: v = 34'sd333772;
				4'd12: v = 34'sd166886;
				4'd13: v = 34'sd83443;
				4'd14: v = 34'sd41722;
				default: v = 34'sd20861;
			endcase
			return v;
		end
	endfunction

	// round q30 product to mm and clamp
	function automatic logic signed [16:0] to_mm(input logic signed [MUL_W-1:0] p);
		logic signed [MUL_W-1:0] t;
		logic signed [17:0] r;
		begin
			t = (p + (MUL_W'(1) <<< 29)) >>> 30;
			if (t > MUL_W'(COORD_LIM)) r = COORD_LIM;
			else if (t < -MUL_W'(COORD_LIM)) r = -COORD_LIM;
			else r = t[17:0];
			return r[16:0];
		end
	endfunction
endpackage
`default_nettype wire

/* hdl/lsp_cordic.sv */
// iterative rotation cordic, one micro-rotation per cycle
// depends on lsp_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsp_cordic import lsp_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [ANGLE_BITS-1:0] angle,
	output logic                       done,
	output cordic_res_t                res
);
	logic busy_q, done_q;
	logic [3:0] i_q;
	logic signed [CW-1:0] c_q, s_q, z_q, cs, ss;
	logic [31:0] u;

	assign u = {angle, {(32-ANGLE_BITS){1'b0}}} - 32'hC000_0000;
	assign cs = c_q >>> i_q;
	assign ss = s_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			c_q <= CORDIC_GAIN;
			s_q <= '0;
			z_q <= CW'($signed(u));
		end else if (busy_q) begin
			if (!z_q[CW-1]) begin
				c_q <= c_q - ss;
				s_q <= s_q + cs;
				z_q <= z_q - atan_turn(i_q);
			end else begin
				c_q <= c_q + ss;
				s_q <= s_q - cs;
				z_q <= z_q + atan_turn(i_q);
			end
		end
	end

	assign done = done_q;
	assign res.s = s_q;
	assign res.c = c_q;
endmodule
`default_nettype wire

/* hdl/lsp_div.sv */
// iterative restoring divider, signed dividend by unsigned divisor, truncating
// depends on lsp_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsp_div import lsp_pkg::*; #(
	parameter int DW = 30,
	parameter int NW = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [DW-1:0] dividend,
	input  wire logic [NW-1:0]        divisor,
	output logic                      done,
	output logic signed [16:0]        quot
);
	localparam int IW = $clog2(DW + 1);
	logic busy_q, done_q, neg_q;
	logic [IW-1:0] n_q;
	logic [DW-1:0] q_q;
	logic [NW-1:0] d_q;
	logic [NW:0] rem_q, trial;
	logic [NW:0] sh;

	assign sh = {rem_q[NW-1:0], q_q[DW-1]};
	assign trial = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			n_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= IW'(DW);
			end else if (busy_q) begin
				n_q <= n_q - IW'(1);
				if (n_q == IW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1];
			q_q <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
			d_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[NW]) begin
				rem_q <= trial;
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(q_q[16:0]) : $signed(q_q[16:0]);
endmodule
`default_nettype wire

/* hdl/lidar_scan_person_cluster.sv */
// top level: apb registers, sequencer, shared multiplier, cluster state
// depends on lsp_pkg, lsp_cordic, lsp_div
//
// channel  | handshake            | word
// in       | in_valid / in_stall  | range_mm, last_of_scan
// out      | out_valid / out_stall| found, center_x, center_y
// cfg      | apb psel/penable     | 8 registers at 4*i
//
// a sample outside the window or range limits is dropped from idle, a kept one runs the
// 16 cordic steps plus shared multiplier passes; closing a cluster adds the two
// serial divisions. in_stall is high while an item is in work. the result word
// waits in an output register; a last item finding it still occupied waits in the
// emit state. reset is asynchronous and clears all but the datapath registers.
`timescale 1ns / 1ps
`default_nettype none
module lidar_scan_person_cluster import lsp_pkg::*; #(
	parameter int MAX_POINTS = 2048,
	parameter int ANGLE_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [15:0]        range_mm,
	input  wire logic               last_of_scan,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    found,
	output logic signed [16:0]      center_x,
	output logic signed [16:0]      center_y
);
	localparam int AW = ANGLE_BITS;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int MW = (CNT_W > 12) ? CNT_W : 12;
	localparam int SUM_W = 18 + $clog2(MAX_POINTS);
	localparam longint WIN_LO = (225 * (longint'(1) << AW) + 359) / 360;
	localparam longint WIN_HI = (315 * (longint'(1) << AW)) / 360;

	localparam logic [2:0] R_ASTART = 3'd0, R_ASTEP = 3'd1, R_RLO = 3'd2, R_RHI = 3'd3,
		R_JD = 3'd4, R_WLO = 3'd5, R_WHI = 3'd6, R_MINP = 3'd7;

	localparam logic [3:0] S_IDLE = 4'd0, S_CORD = 4'd1, S_MX = 4'd2, S_MY = 4'd3,
		S_DX = 4'd4, S_DY = 4'd5, S_JD = 4'd6, S_UPD = 4'd7, S_CL0 = 4'd8,
		S_DIVX = 4'd9, S_DIVY = 4'd10, S_N1 = 4'd11, S_N2 = 4'd12, S_NEXT = 4'd13,
		S_EMIT = 4'd14;

	// registers
	logic [15:0] a_start_q, a_step_q, r_lo_q, r_hi_q, jd_q;
	logic [16:0] w_lo_q, w_hi_q;
	logic [11:0] minp_q;

	logic [3:0] state_q;
	logic [AW-1:0] angle_acc_q, a_q;
	logic [15:0] r_q;
	logic last_q, ret_open_q, joins_q;
	logic signed [16:0] x_q, y_q, prev_x_q, prev_y_q, cl_min_q, cl_max_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [CNT_W-1:0] cnt_q;
	logic cl_open_q, best_v_q;
	logic [36:0] acc_q;
	logic [35:0] best_n2_q;
	logic signed [16:0] best_x_q, best_y_q, cx_q;
	logic out_valid_q, found_q;
	logic signed [16:0] ox_q, oy_q;

	logic wr, accept, keep;
	logic [AW-1:0] a_now;
	logic signed [17:0] mul_a;
	logic signed [CW-1:0] mul_b;
	logic signed [MUL_W-1:0] prod;
	logic [36:0] psq;
	logic signed [17:0] dx, dy, wid;
	logic cord_start, cord_done, div_start, div_done;
	cordic_res_t cres;
	logic signed [SUM_W-1:0] div_n;
	logic signed [16:0] quot, xm;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		unique case (paddr[4:2])
			R_ASTART: prdata = {16'd0, a_start_q};
			R_ASTEP: prdata = {16'd0, a_step_q};
			R_RLO: prdata = {16'd0, r_lo_q};
			R_RHI: prdata = {16'd0, r_hi_q};
			R_JD: prdata = {16'd0, jd_q};
			R_WLO: prdata = {15'd0, w_lo_q};
			R_WHI: prdata = {15'd0, w_hi_q};
			default: prdata = {20'd0, minp_q};
		endcase
	end

	assign a_now = angle_acc_q;
	assign keep = (a_now >= AW'(WIN_LO)) && (a_now <= AW'(WIN_HI))
		&& (range_mm >= r_lo_q) && (range_mm <= r_hi_q);

	assign dx = 18'(x_q) - 18'(prev_x_q);
	assign dy = 18'(y_q) - 18'(prev_y_q);
	assign wid = 18'(cl_max_q) - 18'(cl_min_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MX: begin mul_a = $signed({2'b00, r_q}); mul_b = cres.s; end
			S_MY: begin mul_a = $signed({2'b00, r_q}); mul_b = -cres.c; end
			S_DX: begin mul_a = dx; mul_b = CW'(dx); end
			S_DY: begin mul_a = dy; mul_b = CW'(dy); end
			S_JD: begin mul_a = $signed({2'b00, jd_q}); mul_b = $signed({18'd0, jd_q}); end
			S_N1: begin mul_a = 18'(cx_q); mul_b = CW'(cx_q); end
			S_N2: begin mul_a = 18'(quot); mul_b = CW'(quot); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);
	assign psq = prod[36:0];
	assign xm = to_mm(prod);

	assign cord_start = accept && keep;
	assign div_start = (state_q == S_CL0 && cl_open_q
		&& MW'(cnt_q) >= MW'(minp_q) && cnt_q != '0
		&& !wid[17] && wid[16:0] >= w_lo_q && wid[16:0] <= w_hi_q)
		|| (state_q == S_DIVX && div_done);
	assign div_n = (state_q == S_CL0) ? sum_x_q : sum_y_q;

	lsp_cordic #(.ANGLE_BITS(AW)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .angle(a_now),
		.done(cord_done), .res(cres)
	);

	lsp_div #(.DW(SUM_W), .NW(CNT_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n),
		.divisor(cnt_q), .done(div_done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_start_q <= 16'd0;
			a_step_q <= 16'd182;
			r_lo_q <= 16'd120;
			r_hi_q <= 16'd12000;
			jd_q <= 16'd200;
			w_lo_q <= 17'd300;
			w_hi_q <= 17'd700;
			minp_q <= 12'd3;
			state_q <= S_IDLE;
			angle_acc_q <= '0;
			cl_open_q <= 1'b0;
			best_v_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			ret_open_q <= 1'b0;
			joins_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (wr) begin
				unique case (paddr[4:2])
					R_ASTART: begin
						a_start_q <= pwdata[15:0];
						angle_acc_q <= AW'(pwdata[15:0]);
					end
					R_ASTEP: a_step_q <= pwdata[15:0];
					R_RLO: r_lo_q <= pwdata[15:0];
					R_RHI: r_hi_q <= pwdata[15:0];
					R_JD: jd_q <= pwdata[15:0];
					R_WLO: w_lo_q <= pwdata[16:0];
					R_WHI: w_hi_q <= pwdata[16:0];
					default: minp_q <= pwdata[11:0];
				endcase
			end
			unique case (state_q)
				S_IDLE: if (accept) begin
					last_q <= last_of_scan;
					angle_acc_q <= a_now + AW'(a_step_q);
					ret_open_q <= 1'b0;
					if (keep) state_q <= S_CORD;
					else if (last_of_scan) state_q <= S_CL0;
				end
				S_CORD: if (cord_done) state_q <= S_MX;
				S_MX: state_q <= S_MY;
				S_MY: begin
					joins_q <= 1'b0;
					if (cl_open_q && cnt_q < CNT_W'(MAX_POINTS)) state_q <= S_DX;
					else state_q <= S_UPD;
				end
				S_DX: state_q <= S_DY;
				S_DY: state_q <= S_JD;
				S_JD: begin
					joins_q <= acc_q < psq;
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (joins_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
						state_q <= last_q ? S_CL0 : S_IDLE;
					end else begin
						ret_open_q <= 1'b1;
						state_q <= S_CL0;
					end
				end
				S_CL0: begin
					cl_open_q <= 1'b0;
					state_q <= div_start ? S_DIVX : S_NEXT;
				end
				S_DIVX: if (div_done) state_q <= S_DIVY;
				S_DIVY: if (div_done) state_q <= S_N1;
				S_N1: state_q <= S_N2;
				S_N2: begin
					if (!best_v_q || {1'b0, acc_q[35:0]} + {1'b0, psq[35:0]} < {1'b0, best_n2_q})
						best_v_q <= 1'b1;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (ret_open_q) begin
						cl_open_q <= 1'b1;
						cnt_q <= CNT_W'(1);
						ret_open_q <= 1'b0;
						state_q <= last_q ? S_CL0 : S_IDLE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: if (!out_valid_q || !out_stall) begin
					best_v_q <= 1'b0;
					cl_open_q <= 1'b0;
					cnt_q <= '0;
					angle_acc_q <= AW'(a_start_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) r_q <= range_mm;
			S_MX: x_q <= xm;
			S_MY: y_q <= xm;
			S_DX: acc_q <= psq;
			S_DY: acc_q <= acc_q + psq;
			S_UPD: begin
				if (joins_q) begin
					if (x_q < cl_min_q) cl_min_q <= x_q;
					if (x_q > cl_max_q) cl_max_q <= x_q;
					sum_x_q <= sum_x_q + SUM_W'(x_q);
					sum_y_q <= sum_y_q + SUM_W'(y_q);
				end
				prev_x_q <= x_q;
				prev_y_q <= y_q;
			end
			S_DIVX: if (div_done) cx_q <= quot;
			S_N1: acc_q <= psq;
			S_N2: if (!best_v_q || {1'b0, acc_q[35:0]} + {1'b0, psq[35:0]} < {1'b0, best_n2_q})
			begin
				best_n2_q <= acc_q[35:0] + psq[35:0];
				best_x_q <= cx_q;
				best_y_q <= quot;
			end
			S_NEXT: if (ret_open_q) begin
				cl_min_q <= x_q;
				cl_max_q <= x_q;
				sum_x_q <= SUM_W'(x_q);
				sum_y_q <= SUM_W'(y_q);
			end
			S_EMIT: if (!out_valid_q || !out_stall) begin
				found_q <= best_v_q;
				ox_q <= best_v_q ? best_x_q : 17'sd0;
				oy_q <= best_v_q ? best_y_q : 17'sd0;
				prev_x_q <= '0;
				prev_y_q <= '0;
			end
			default: ;
		endcase
	end

	assign a_q = angle_acc_q;
	assign out_valid = out_valid_q;
	assign found = found_q;
	assign center_x = ox_q;
	assign center_y = oy_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS)) else $error("cluster count overflow");
	a_open_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cl_open_q) |-> cnt_q != '0) else $error("open cluster empty");
	a_minmax: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cl_open_q) |-> cl_max_q >= cl_min_q)
		else $error("cluster bounds inverted");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && !out_stall) |=> state_q == S_IDLE
		&& a_q == AW'(a_start_q)) else $error("scan not cleared after emit");
endmodule
`default_nettype wire

/* tb/lidar_scan_person_cluster_test.sv */
// testbench for lidar_scan_person_cluster: drives range words in scans and checks
// each scan result against a cordic and clustering predictor kept here
// depends on lsp_pkg and lidar_scan_person_cluster
`timescale 1ns / 1ps
`default_nettype none
module lidar_scan_person_cluster_test;
	import lsp_pkg::*;

	localparam int POINT_CAP = 2048;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 300;
	localparam int LONG_HOLD = 2500;

	typedef enum int {
		REG_ANGLE_START = 0, REG_ANGLE_STEP = 1, REG_RANGE_LOW = 2, REG_RANGE_HIGH = 3,
		REG_JOIN_DIST = 4, REG_WIDTH_LOW = 5, REG_WIDTH_HIGH = 6, REG_MIN_POINTS = 7
	} reg_idx_e;

	typedef struct {
		logic [15:0] range;
		logic last;
	} sample_t;

	typedef struct {
		logic found;
		logic [16:0] cx;
		logic [16:0] cy;
	} person_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [15:0] range_mm = '0;
	logic last_of_scan = 0;
	logic out_valid;
	logic out_stall = 0;
	logic found;
	logic signed [16:0] center_x, center_y;

	lidar_scan_person_cluster u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .range_mm(range_mm),
		.last_of_scan(last_of_scan), .out_valid(out_valid), .out_stall(out_stall),
		.found(found), .center_x(center_x), .center_y(center_y)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// configuration copy
	longint cfg_start = 0, cfg_step = 182, cfg_rlo = 120, cfg_rhi = 12000, cfg_join = 200;
	longint cfg_wlo = 300, cfg_whi = 700, cfg_minpts = 3;
	// scan state copy
	longint angle_acc = 0;
	bit clus_open = 0;
	longint prev_x = 0, prev_y = 0, min_x = 0, max_x = 0, sum_x = 0, sum_y = 0, clus_n = 0;
	bit best_ok = 0;
	longint best_n2 = 0, best_x = 0, best_y = 0;

	sample_t pend_q[$];
	person_t person_q[$];
	int err_count = 0;
	int words_in = 0, words_out = 0, found_count = 0;
	longint cycles = 0;
	bit sender_hold = 0;
	bit quiet = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int in_gap = 0;
	bit in_taken = 0;

	const longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861};

	function automatic longint mm_of(longint r, longint q);
		longint v;
		v = (r * q + (64'sd1 <<< 29)) >>> 30;
		if (v > 65535) v = 65535;
		if (v < -65535) v = -65535;
		return v;
	endfunction

	task automatic rotate(input longint a, input longint r, output longint x, output longint y);
		logic [31:0] u;
		longint z, c, s, cs, ss;
		u = 32'(a << 16) - 32'hC0000000;
		z = longint'(signed'(u));
		c = 652032874;
		s = 0;
		for (int i = 0; i < 16; i++) begin
			cs = c >>> i;
			ss = s >>> i;
			if (z >= 0) begin
				c -= ss; s += cs; z -= atan_tab[i];
			end else begin
				c += ss; s -= cs; z += atan_tab[i];
			end
		end
		x = mm_of(r, s);
		y = mm_of(r, -c);
	endtask

	task automatic close_clus();
		longint w, cx, cy, n2;
		if (!clus_open) return;
		clus_open = 0;
		if (clus_n < cfg_minpts || clus_n == 0) return;
		w = max_x - min_x;
		if (w < cfg_wlo || w > cfg_whi) return;
		cx = sum_x / clus_n;
		cy = sum_y / clus_n;
		n2 = cx * cx + cy * cy;
		if (!best_ok || n2 < best_n2) begin
			best_ok = 1; best_n2 = n2; best_x = cx; best_y = cy;
		end
	endtask

	task automatic clear_scan();
		angle_acc = cfg_start;
		clus_open = 0;
		prev_x = 0; prev_y = 0; min_x = 0; max_x = 0; sum_x = 0; sum_y = 0; clus_n = 0;
		best_ok = 0; best_n2 = 0; best_x = 0; best_y = 0;
	endtask

	task automatic predict_sample(input sample_t it);
		longint a, r, x, y, dx, dy;
		bit joins;
		person_t p;
		a = angle_acc & 16'hFFFF;
		r = it.range;
		if (a * 360 >= (longint'(225) << 16) && a * 360 <= (longint'(315) << 16) &&
				r >= cfg_rlo && r <= cfg_rhi) begin
			rotate(a, r, x, y);
			joins = 0;
			if (clus_open && clus_n < POINT_CAP) begin
				dx = x - prev_x;
				dy = y - prev_y;
				joins = (dx * dx + dy * dy) < cfg_join * cfg_join;
			end
			if (joins) begin
				if (x < min_x) min_x = x;
				if (x > max_x) max_x = x;
				sum_x += x; sum_y += y; clus_n++;
			end else begin
				close_clus();
				clus_open = 1; min_x = x; max_x = x; sum_x = x; sum_y = y; clus_n = 1;
			end
			prev_x = x; prev_y = y;
		end
		angle_acc = (a + cfg_step) & 16'hFFFF;
		if (it.last) begin
			close_clus();
			p.found = best_ok;
			p.cx = best_ok ? 17'(best_x) : '0;
			p.cy = best_ok ? 17'(best_y) : '0;
			person_q.insert(person_q.size(), p);
			clear_scan();
		end
	endtask

	function automatic int pick_gap();
		int k;
		if (quiet) return 0;
		k = $urandom_range(99);
		if (k < 65) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// input side and result checking
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lidar_scan_person_cluster regression: fail");
			$finish;
		end
		if (in_valid && !in_stall) begin
			sample_t s;
			s.range = range_mm;
			s.last = last_of_scan;
			predict_sample(s);
			words_in++;
			in_taken = 1;
		end
		if (out_valid && !out_stall) begin
			person_t e;
			words_out++;
			if (found) found_count++;
			if (person_q.size() == 0) begin
				err_count++;
				if (err_count <= 10) $display("unexpected result word found=%0d x=%0d y=%0d",
					found, center_x, center_y);
			end else begin
				e = person_q.pop_front();
				if (e.found !== found || e.cx !== center_x || e.cy !== center_y) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: exp found=%0d x=%0d y=%0d got found=%0d x=%0d y=%0d",
							e.found, signed'(e.cx), signed'(e.cy), found, center_x, center_y);
				end
			end
		end
	end

	// sender
	always @(negedge clk) begin
		sample_t s;
		logic nv;
		nv = in_valid;
		if (!in_valid || in_taken) begin
			if (in_taken) in_gap = pick_gap();
			in_taken = 0;
			if (in_gap > 0) begin
				in_gap--;
				nv = 0;
			end else if (!sender_hold && pend_q.size() > 0) begin
				s = pend_q.pop_front();
				range_mm <= s.range;
				last_of_scan <= s.last;
				nv = 1;
			end else begin
				nv = 0;
			end
		end
		in_valid <= nv;
	end

	// receiver
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else if (hold_req) begin
			hold_req = 0;
			hold_left = LONG_HOLD;
			out_stall <= 1;
		end else begin
			out_stall <= (pick_gap() > 0);
		end
	end

	task automatic reg_write(input reg_idx_e idx, input longint value);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(4 * idx); pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_ANGLE_START: begin cfg_start = value & 16'hFFFF; angle_acc = cfg_start; end
			REG_ANGLE_STEP: cfg_step = value & 16'hFFFF;
			REG_RANGE_LOW: cfg_rlo = value & 16'hFFFF;
			REG_RANGE_HIGH: cfg_rhi = value & 16'hFFFF;
			REG_JOIN_DIST: cfg_join = value & 16'hFFFF;
			REG_WIDTH_LOW: cfg_wlo = value & 17'h1FFFF;
			REG_WIDTH_HIGH: cfg_whi = value & 17'h1FFFF;
			REG_MIN_POINTS: cfg_minpts = value & 12'hFFF;
			default: ;
		endcase
	endtask

	task automatic set_all(input longint st, input longint sp, input longint lo, input longint hi,
			input longint jd, input longint wl, input longint wh, input longint mp);
		reg_write(REG_ANGLE_START, st);
		reg_write(REG_ANGLE_STEP, sp);
		reg_write(REG_RANGE_LOW, lo);
		reg_write(REG_RANGE_HIGH, hi);
		reg_write(REG_JOIN_DIST, jd);
		reg_write(REG_WIDTH_LOW, wl);
		reg_write(REG_WIDTH_HIGH, wh);
		reg_write(REG_MIN_POINTS, mp);
	endtask

	task automatic push(input int r, input bit l);
		sample_t s;
		s.range = 16'(r);
		s.last = l;
		pend_q.insert(pend_q.size(), s);
	endtask

	task automatic drain();
		while (pend_q.size() > 0 || in_valid || person_q.size() > 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// one scan of n words: runs of near-constant range with some noise
	task automatic push_scan(input int n);
		int left, base, r;
		left = 0;
		base = 0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) begin
				left = $urandom_range(1, 30);
				case ($urandom_range(9))
					0: base = $urandom_range(0, 200);
					1: base = $urandom_range(12000, 65535);
					2, 3: base = $urandom_range(3000, 9000);
					default: base = $urandom_range(300, 2500);
				endcase
			end
			left--;
			if ($urandom_range(19) == 0) r = $urandom_range(0, 65535);
			else r = base + $urandom_range(0, 40) - 20;
			if (r < 0) r = 0;
			if (r > 65535) r = 65535;
			push(r, i == n - 1);
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);

		// directed: extremes and a person-sized group at the window start
		set_all(40960, 182, 120, 12000, 200, 300, 700, 3);
		push(0, 0); push(65535, 0); push(119, 0); push(120, 0); push(12000, 0); push(12001, 0);
		for (int i = 0; i < 14; i++) push(900 + i, 0);
		push(5000, 1);
		push(1000, 1);
		drain();

		// angle wrap, widest limits, min_points of zero
		set_all(30000, 300, 0, 65535, 65535, 0, 131071, 0);
		push_scan(150);
		push(65535, 0); push(65535, 1);
		drain();

		// inverted limits, zero join distance, fixed angle
		set_all(49152, 0, 5000, 100, 0, 700, 300, 4095);
		push_scan(20);
		drain();
		set_all(49152, 0, 100, 5000, 0, 0, 131071, 1);
		push_scan(20);
		drain();

		// long receiver hold while short scans keep coming
		set_all(40960, 182, 120, 12000, 200, 300, 700, 3);
		hold_req = 1;
		for (int i = 0; i < 12; i++) push_scan($urandom_range(1, 6));
		drain();

		// random scans under varied settings
		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph == 3);
			set_all($urandom_range(36000, 44000), $urandom_range(60, 500),
				$urandom_range(0, 500), $urandom_range(2000, 65535),
				$urandom_range(20, 1200), $urandom_range(0, 400),
				(ph == 5) ? 131071 : $urandom_range(400, 3000), $urandom_range(1, 8));
			for (int k = 0; k < 4; k++) push_scan($urandom_range(10, 32));
			sender_hold = 1;
			while (person_q.size() > 0 || in_valid) @(negedge clk);
			sender_hold = 0;
			for (int k = 0; k < 3; k++) push_scan($urandom_range(10, 32));
			drain();
		end
		quiet = 0;

		$display("covered %0d input words and %0d result words, %0d with a person found",
			words_in, words_out, found_count);
		if (err_count == 0)
			$display("lidar_scan_person_cluster regression: pass");
		else
			$display("lidar_scan_person_cluster regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
hdl/lsp_pkg.sv
hdl/lsp_cordic.sv
hdl/lsp_div.sv
hdl/lidar_scan_person_cluster.sv
tb/lidar_scan_person_cluster_test.sv
